[hw/rtl/tkc_pkg.sv]
// Package for the touch-key camera control block.
// Holds key window constants, key codes and the camera command type.
// No dependencies.
`default_nettype none

package tkc_pkg;

  // Shared key column on the x axis
  localparam logic [7:0] ColLo = 8'hC9;
  localparam logic [7:0] ColHi = 8'hF1;

  localparam int unsigned NumKeys = 6;

  // Per-key y windows, inclusive
  localparam logic [7:0] WinLo [NumKeys] = '{8'h17, 8'h3D, 8'h62, 8'h88, 8'hAE, 8'hD3};
  localparam logic [7:0] WinHi [NumKeys] = '{8'h33, 8'h58, 8'h7E, 8'hA4, 8'hC9, 8'hEF};

  // Key codes
  localparam logic [2:0] KeyRun    = 3'd0;
  localparam logic [2:0] KeyMode   = 3'd1;
  localparam logic [2:0] KeyForce  = 3'd2;
  localparam logic [2:0] KeyExpUp  = 3'd4;
  localparam logic [2:0] KeyExpDn  = 3'd5;
  localparam logic [2:0] NoKey     = 3'd6;

  localparam logic [2:0]  ModeForced    = 3'd4;
  localparam logic [15:0] ExposureReset = 16'h0400;
  localparam logic [15:0] StepReset     = 16'h0100;

  // Camera command codes
  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdStop  = 2'd1,
    CmdStart = 2'd2,
    CmdLoad  = 2'd3
  } cam_cmd_e;

endpackage

`default_nettype wire

[hw/rtl/touch_key_camera_control.sv]
// Touch-key camera control: key decode, LED pattern, run/mode/exposure state.
// Depends on tkc_pkg.
`default_nettype none

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid_i/in_ready_o | pen_down, touch_x, touch_y, press_edge
//  out     | output    | out_valid_o/out_ready_i | key_code, led_*, camera_cmd, exposure,
//          |           |                       | mode_write, mode_value
//  cfg     | input     | cfg_valid_i/cfg_ready_o | exposure_step
//
// An event passes from the input register to the result register; one event
// is accepted every cycle unless a stalled result register holds the flow.
// Camera state updates as an event moves into the result register, so the
// next event in the input register already sees it.
// A stalled result register holds both stages; the input side stays open
// while the input register is empty or moving. Reset is asynchronous, low.
module touch_key_camera_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        pen_down_i,
  input  wire logic [7:0]  touch_x_i,
  input  wire logic [7:0]  touch_y_i,
  input  wire logic        press_edge_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       key_code_o,
  output logic             led_write_o,
  output logic [5:0]       led_mask_o,
  output logic [1:0]       camera_cmd_o,
  output logic [15:0]      exposure_value_o,
  output logic             mode_write_o,
  output logic [2:0]       mode_value_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  // Input register
  logic       s1_valid_q;
  logic       pen_q, edge_q;
  logic [7:0] x_q, y_q;

  // State
  logic        running_q, running_d;
  logic [1:0]  mode_cnt_q, mode_cnt_d;
  logic [15:0] exposure_q, exposure_d;
  logic [15:0] step_q;

  // Result register
  logic               out_valid_q;
  logic [2:0]         key_q, key_d;
  logic               led_wr_q, led_wr_d;
  logic [5:0]         led_mask_q, led_mask_d;
  tkc_pkg::cam_cmd_e  cmd_q, cmd_d;
  logic               mode_wr_q, mode_wr_d;
  logic [2:0]         mode_val_q, mode_val_d;

  logic        advance;
  logic        in_col;
  logic        hit;
  logic [16:0] exp_sum;

  // Flow control
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pen_q  <= pen_down_i;
      x_q    <= touch_x_i;
      y_q    <= touch_y_i;
      edge_q <= press_edge_i;
    end
  end

  // Key decode against the six y windows
  always_comb begin
    in_col     = pen_q && (x_q >= tkc_pkg::ColLo) && (x_q <= tkc_pkg::ColHi);
    hit        = 1'b0;
    key_d      = tkc_pkg::NoKey;
    led_mask_d = '0;
    if (in_col) begin
      for (int k = 0; k < tkc_pkg::NumKeys; k++) begin
        if ((y_q >= tkc_pkg::WinLo[k]) && (y_q <= tkc_pkg::WinHi[k])) begin
          hit        = 1'b1;
          key_d      = 3'(k);
          led_mask_d = 6'(1) << k;
        end
      end
    end
    led_wr_d = !in_col || hit;
  end

  // Key action on a press edge
  assign exp_sum = {1'b0, exposure_q} + {1'b0, step_q};

  always_comb begin
    running_d  = running_q;
    mode_cnt_d = mode_cnt_q;
    exposure_d = exposure_q;
    cmd_d      = tkc_pkg::CmdNone;
    mode_wr_d  = 1'b0;
    mode_val_d = '0;
    if (edge_q) begin
      case (key_d)
        tkc_pkg::KeyRun: begin
          cmd_d     = running_q ? tkc_pkg::CmdStop : tkc_pkg::CmdStart;
          running_d = !running_q;
        end
        tkc_pkg::KeyMode: begin
          mode_cnt_d = mode_cnt_q + 2'd1;
          mode_wr_d  = 1'b1;
          mode_val_d = {1'b0, mode_cnt_d};
        end
        tkc_pkg::KeyForce: begin
          mode_wr_d  = 1'b1;
          mode_val_d = tkc_pkg::ModeForced;
        end
        tkc_pkg::KeyExpUp: begin
          if (!exp_sum[16]) begin
            exposure_d = exp_sum[15:0];
          end
          cmd_d = tkc_pkg::CmdLoad;
        end
        tkc_pkg::KeyExpDn: begin
          if (exposure_q >= step_q) begin
            exposure_d = exposure_q - step_q;
          end
          cmd_d = tkc_pkg::CmdLoad;
        end
        default: begin
        end
      endcase
    end
  end

  // State and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b1;
      mode_cnt_q <= '0;
      exposure_q <= tkc_pkg::ExposureReset;
      step_q     <= tkc_pkg::StepReset;
    end else begin
      if (advance) begin
        running_q  <= running_d;
        mode_cnt_q <= mode_cnt_d;
        exposure_q <= exposure_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_q      <= key_d;
      led_wr_q   <= led_wr_d;
      led_mask_q <= led_mask_d;
      cmd_q      <= cmd_d;
      mode_wr_q  <= mode_wr_d;
      mode_val_q <= mode_val_d;
    end
  end

  // Outputs; exposure register always holds the value after the last result
  assign out_valid_o      = out_valid_q;
  assign key_code_o       = key_q;
  assign led_write_o      = led_wr_q;
  assign led_mask_o       = led_mask_q;
  assign camera_cmd_o     = cmd_q;
  assign exposure_value_o = exposure_q;
  assign mode_write_o     = mode_wr_q;
  assign mode_value_o     = mode_val_q;

  // Assertions
  a_key_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (key_q != tkc_pkg::NoKey) |-> led_wr_q && $onehot(led_mask_q))
    else $error("decoded key without one-hot LED pattern");

  a_load_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (cmd_q == tkc_pkg::CmdLoad)
      |-> (key_q == tkc_pkg::KeyExpUp) || (key_q == tkc_pkg::KeyExpDn))
    else $error("exposure load from a non-exposure key");

  a_mode_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && mode_wr_q
      |-> (key_q == tkc_pkg::KeyMode) || (key_q == tkc_pkg::KeyForce))
    else $error("mode issued from a non-mode key");

  a_exp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(exposure_q) && $stable(running_q) && $stable(mode_cnt_q))
    else $error("camera state changed without an event moving");

endmodule

`default_nettype wire
